// ----- hdl/sfcr_pkg.sv -----
// Shared constants, types and the CRC-16 byte update of the stuffed frame receiver.
// No dependencies; every other file of the block refers to this package by scope.
`default_nettype none

package sfcr_pkg;

    localparam logic [7:0]  SYM_START = 8'h8D;
    localparam logic [7:0]  SYM_END   = 8'h8E;
    localparam logic [7:0]  SYM_ESC   = 8'h8F;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_RESET = 16'h5635;
    localparam int          MIN_FRAME = 4;
    localparam int          MAX_LENGTH_RESET = 256;
    localparam int          LENGTH_LIMIT_DEF = 4096;
    localparam int          QUEUE_DEPTH = 2;

    localparam int          CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT   = 2'd1;

    localparam int          MAX_LENGTH_W = 13;
    localparam int          CFG_DATA_W   = 16;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_STORED    = 3'd1,
        EV_FRAME_OK  = 3'd2,
        EV_CRC_ERR   = 3'd3,
        EV_TOO_SHORT = 3'd4,
        EV_OVERFLOW  = 3'd5,
        EV_BAD_ESC   = 3'd6
    } t_event;

    // What the front end decided a received byte means
    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_START   = 3'd1,
        K_END     = 3'd2,
        K_STORE   = 3'd3,
        K_BAD_ESC = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_item;

    // CRC-16, polynomial 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sfcr_if.sv -----
// Valid/ready channel interfaces: received bytes, result items, register writes.
// Depends on sfcr_pkg for the register index and data widths.
`default_nettype none

interface sfcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [11:0] byte_index;
    logic [11:0] payload_length;
    modport source (output valid, output event_res, output data_byte, output byte_index,
                    output payload_length, input ready);
    modport sink   (input valid, input event_res, input data_byte, input byte_index,
                    input payload_length, output ready);
endinterface

interface sfcr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sfcr_pkg::CFG_IDX_W-1:0] reg_index;
    logic [sfcr_pkg::CFG_DATA_W-1:0] wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/sfcr_front.sv -----
// Front end: takes raw bytes, resolves escapes and classifies each byte for the back end.
// Depends on sfcr_pkg and sfcr_in_if.
`default_nettype none

module sfcr_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    sfcr_in_if.sink              i_rx,
    input  wire logic            i_full,
    output sfcr_pkg::t_item      o_item,
    output logic                 o_push
);

    logic       r_esc;
    logic       n_esc;
    logic [7:0] w_inv;

    assign i_rx.ready = !i_full;
    assign o_push     = i_rx.valid && !i_full;
    assign w_inv      = ~i_rx.rx_byte;

    always_comb begin
        o_item.value = i_rx.rx_byte;
        o_item.kind  = sfcr_pkg::K_NONE;
        n_esc        = r_esc;
        if (r_esc) begin
            n_esc        = 1'b0;
            o_item.value = w_inv;
            if (w_inv == sfcr_pkg::SYM_START || w_inv == sfcr_pkg::SYM_END ||
                w_inv == sfcr_pkg::SYM_ESC) begin
                o_item.kind = sfcr_pkg::K_STORE;
            end else begin
                o_item.kind = sfcr_pkg::K_BAD_ESC;
            end
        end else begin
            case (i_rx.rx_byte)
                sfcr_pkg::SYM_START: o_item.kind = sfcr_pkg::K_START;
                sfcr_pkg::SYM_END:   o_item.kind = sfcr_pkg::K_END;
                sfcr_pkg::SYM_ESC: begin
                    o_item.kind = sfcr_pkg::K_NONE;
                    n_esc       = 1'b1;
                end
                default:             o_item.kind = sfcr_pkg::K_STORE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else if (o_push) begin
            r_esc <= n_esc;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sfcr_queue.sv -----
// Short queue of classified bytes between the front and back ends.
// Depends on sfcr_pkg.
`default_nettype none

module sfcr_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  sfcr_pkg::t_item      i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output sfcr_pkg::t_item      o_item,
    output logic                 o_empty
);

    localparam int DEPTH = sfcr_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    sfcr_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [NW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= NW'(r_count + 1'b1);
            end else if (w_pop && !w_push) begin
                r_count <= NW'(r_count - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sfcr_back.sv -----
// Back end: frame count, running CRC, limit checks, registers and the result register.
// Depends on sfcr_pkg, sfcr_out_if and sfcr_cfg_if.
`default_nettype none

module sfcr_back #(
    parameter int LENGTH_LIMIT = sfcr_pkg::LENGTH_LIMIT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  sfcr_pkg::t_item      i_item,
    input  wire logic            i_empty,
    output logic                 o_pop,
    sfcr_out_if.source           o_res,
    sfcr_cfg_if.sink             i_cfg
);

    localparam int CW = $clog2(LENGTH_LIMIT + 1);
    localparam int EW = (CW > 12) ? CW : 12;
    localparam int MW = (CW > sfcr_pkg::MAX_LENGTH_W) ? CW : sfcr_pkg::MAX_LENGTH_W;
    localparam int LIMIT_RESET = (sfcr_pkg::MAX_LENGTH_RESET > LENGTH_LIMIT) ?
                                 LENGTH_LIMIT : sfcr_pkg::MAX_LENGTH_RESET;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [15:0]    r_crc;
    logic [15:0]    n_crc;
    logic [15:0]    r_crc_init;
    logic [CW-1:0]  r_limit;
    logic           r_out_valid;
    sfcr_pkg::t_event r_event;
    sfcr_pkg::t_event n_event;
    logic [7:0]     r_data;
    logic [7:0]     n_data;
    logic [11:0]    r_index;
    logic [11:0]    n_index;
    logic [11:0]    r_length;
    logic [11:0]    n_length;
    logic [EW-1:0]  w_count_ext;
    logic [MW-1:0]  w_max_len;
    logic           w_cfg_wr;

    assign o_pop        = !i_empty && (!r_out_valid || o_res.ready);
    assign w_count_ext  = EW'(r_count);
    assign w_max_len    = MW'(i_cfg.wr_data[sfcr_pkg::MAX_LENGTH_W-1:0]);
    assign i_cfg.ready  = 1'b1;
    assign w_cfg_wr     = i_cfg.valid;

    assign o_res.valid          = r_out_valid;
    assign o_res.event_res      = r_event;
    assign o_res.data_byte      = r_data;
    assign o_res.byte_index     = r_index;
    assign o_res.payload_length = r_length;

    always_comb begin
        n_count  = r_count;
        n_crc    = r_crc;
        n_event  = sfcr_pkg::EV_NONE;
        n_data   = '0;
        n_index  = '0;
        n_length = '0;
        case (i_item.kind)
            sfcr_pkg::K_NONE: begin
                n_event = sfcr_pkg::EV_NONE;
            end
            sfcr_pkg::K_START: begin
                n_count = '0;
                n_crc   = r_crc_init;
            end
            sfcr_pkg::K_BAD_ESC: begin
                n_event = sfcr_pkg::EV_BAD_ESC;
                n_count = '0;
                n_crc   = r_crc_init;
            end
            sfcr_pkg::K_END: begin
                if (w_count_ext < EW'(sfcr_pkg::MIN_FRAME)) begin
                    n_event = sfcr_pkg::EV_TOO_SHORT;
                end else if (r_crc != '0) begin
                    n_event = sfcr_pkg::EV_CRC_ERR;
                end else begin
                    n_event  = sfcr_pkg::EV_FRAME_OK;
                    n_length = w_count_ext[11:0] - 12'd2;
                end
                n_count = '0;
                n_crc   = r_crc_init;
            end
            sfcr_pkg::K_STORE: begin
                if (r_count >= r_limit) begin
                    // frame full: drop the byte and start over
                    n_event = sfcr_pkg::EV_OVERFLOW;
                    n_count = '0;
                    n_crc   = r_crc_init;
                end else begin
                    n_event = sfcr_pkg::EV_STORED;
                    n_data  = i_item.value;
                    n_index = w_count_ext[11:0];
                    n_crc   = sfcr_pkg::crc_byte(r_crc, i_item.value);
                    n_count = CW'(r_count + 1'b1);
                end
            end
            default: begin
                n_event = sfcr_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_crc       <= sfcr_pkg::CRC_RESET;
            r_crc_init  <= sfcr_pkg::CRC_RESET;
            r_limit     <= CW'(LIMIT_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (i_cfg.reg_index)
                    sfcr_pkg::CFG_MAX_LENGTH: begin
                        // cap at the build-time limit
                        if (w_max_len > MW'(LENGTH_LIMIT)) begin
                            r_limit <= CW'(LENGTH_LIMIT);
                        end else begin
                            r_limit <= CW'(w_max_len);
                        end
                    end
                    sfcr_pkg::CFG_CRC_INIT: r_crc_init <= i_cfg.wr_data;
                    default: ;
                endcase
            end
            if (o_pop) begin
                r_count     <= n_count;
                r_crc       <= n_crc;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_event  <= n_event;
            r_data   <= n_data;
            r_index  <= n_index;
            r_length <= n_length;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LENGTH_LIMIT))
        else $error("frame byte count above length limit");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.kind == sfcr_pkg::K_START |=> r_count == '0 && r_crc == r_crc_init)
        else $error("start byte did not restart the frame");

    a_store_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.kind == sfcr_pkg::K_STORE && r_count < r_limit
        |=> r_count == CW'($past(r_count) + 1'b1) && r_event == sfcr_pkg::EV_STORED)
        else $error("stored byte did not advance the count");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !o_pop)
        else $error("queue popped while result stalled");

endmodule

`default_nettype wire

// ----- hdl/stuffed_frame_crc16_receiver.sv -----
// Top level of the byte-stuffed frame receiver with CRC-16 check.
// Depends on sfcr_pkg, sfcr_if, sfcr_front, sfcr_queue and sfcr_back.
//
// Usage:
//   i_rx carries one raw link byte per transfer; o_res returns exactly one result
//   per byte: an event code, and for a stored byte the unstuffed value and its
//   index, for a good frame the payload length without the two CRC bytes.
//   i_cfg writes register 0 (max_length, capped at LENGTH_LIMIT) and register 1
//   (crc_init, loaded at each frame restart); it is always ready. The user must
//   write it only while no byte is in flight; the block does not enforce this.
//   Path: a byte accepted from i_rx is written into the queue, then taken into
//   the result register once that is free or o_res.ready is high.
//   Throughput: one byte per cycle while o_res.ready stays high; the CRC update
//   is one byte-wide step per cycle in the back end.
//   Reset (i_rst_n low, synchronous): queue and result register empty, escape
//   cleared, count zero, CRC and crc_init 0x5635, max_length 256 (LENGTH_LIMIT if lower).
//   Stall: the result register holds while o_res.ready is low; the two-entry
//   queue keeps taking bytes until it is full, then i_rx.ready drops.
`default_nettype none

module stuffed_frame_crc16_receiver #(
    parameter int LENGTH_LIMIT = sfcr_pkg::LENGTH_LIMIT_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sfcr_in_if.sink      i_rx,
    sfcr_out_if.source   o_res,
    sfcr_cfg_if.sink     i_cfg
);

    sfcr_pkg::t_item w_front_item;
    sfcr_pkg::t_item w_queue_item;
    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_empty;

    sfcr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (w_full),
        .o_item  (w_front_item),
        .o_push  (w_push)
    );

    sfcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_empty (w_empty)
    );

    sfcr_back #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_queue_item),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_res   (o_res),
        .i_cfg   (i_cfg)
    );

endmodule

`default_nettype wire

// ----- sim/tb_stuffed_frame_crc16_receiver.sv -----
// Self-checking testbench for the byte-stuffed frame receiver with CRC-16 check.
// Depends on sfcr_pkg, the channel interfaces in sfcr_if and the receiver RTL.
// Drives stuffed link bytes with random gaps and stalls, and checks every result.

module tb_stuffed_frame_crc16_receiver;

    localparam int LEN_CAP      = sfcr_pkg::LENGTH_LIMIT_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int ITEM_GOAL    = 1450;

    typedef struct {
        logic [7:0] value;
        bit         drain;
    } t_link_byte;

    typedef struct {
        sfcr_pkg::t_event ev;
        logic [7:0]       data;
        logic [11:0]      index;
        logic [11:0]      plen;
    } t_deframe_result;

    logic i_clk;
    logic i_rst_n;

    sfcr_in_if  rx_ch ();
    sfcr_out_if res_ch ();
    sfcr_cfg_if cfg_ch ();

    // register shadow, updated on each register write transfer
    logic [12:0] cfg_max_length = 13'd256;
    logic [15:0] cfg_crc_init   = sfcr_pkg::CRC_RESET;

    // deframer state as the block should hold it
    bit          esc_pending = 1'b0;
    int          frame_len   = 0;
    logic [15:0] frame_crc   = sfcr_pkg::CRC_RESET;

    t_link_byte      pending_link_bytes[$];
    t_deframe_result due_results[$];
    logic [7:0]      frame_vals[$];

    bit rx_taken     = 1'b0;
    bit drain_next   = 1'b0;
    bit rx_idle_on   = 1'b1;
    bit res_idle_on  = 1'b1;
    int rx_gap       = 0;
    int res_stall    = 0;
    int errors       = 0;
    int cycle_count  = 0;
    int bytes_queued = 0;

    stuffed_frame_crc16_receiver i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] v);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ v[i];
            r = {r[14:0], 1'b0} ^ (fb ? sfcr_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic int length_cap();
        return (int'(cfg_max_length) > LEN_CAP) ? LEN_CAP : int'(cfg_max_length);
    endfunction

    function automatic void restart_frame();
        esc_pending = 1'b0;
        frame_len   = 0;
        frame_crc   = cfg_crc_init;
    endfunction

    function automatic t_deframe_result store_value(input logic [7:0] v);
        t_deframe_result r;
        r = '{sfcr_pkg::EV_NONE, 8'h00, 12'h000, 12'h000};
        if (frame_len >= length_cap()) begin
            // full frame: drop the byte and start over
            restart_frame();
            r.ev = sfcr_pkg::EV_OVERFLOW;
        end else begin
            r.ev    = sfcr_pkg::EV_STORED;
            r.data  = v;
            r.index = 12'(frame_len);
            frame_crc = crc16_step(frame_crc, v);
            frame_len++;
        end
        return r;
    endfunction

    function automatic t_deframe_result deframe_byte(input logic [7:0] b);
        t_deframe_result r;
        logic [7:0]      x;
        r = '{sfcr_pkg::EV_NONE, 8'h00, 12'h000, 12'h000};
        if (esc_pending) begin
            x = ~b;
            esc_pending = 1'b0;
            if (x == sfcr_pkg::SYM_START || x == sfcr_pkg::SYM_END ||
                x == sfcr_pkg::SYM_ESC) begin
                r = store_value(x);
            end else begin
                restart_frame();
                r.ev = sfcr_pkg::EV_BAD_ESC;
            end
        end else if (b == sfcr_pkg::SYM_START) begin
            restart_frame();
        end else if (b == sfcr_pkg::SYM_ESC) begin
            esc_pending = 1'b1;
        end else if (b == sfcr_pkg::SYM_END) begin
            if (frame_len < sfcr_pkg::MIN_FRAME) begin
                r.ev = sfcr_pkg::EV_TOO_SHORT;
            end else if (frame_crc != 16'h0000) begin
                r.ev = sfcr_pkg::EV_CRC_ERR;
            end else begin
                r.ev   = sfcr_pkg::EV_FRAME_OK;
                r.plen = 12'(frame_len - 2);
            end
            restart_frame();
        end else begin
            r = store_value(b);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 16);
    endfunction

    function automatic logic [7:0] pick_payload();
        if ($urandom_range(0, 4) == 0) begin
            return 8'(sfcr_pkg::SYM_START + $urandom_range(0, 2));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void push_raw(input logic [7:0] b);
        pending_link_bytes.push_back('{value: b, drain: drain_next});
        drain_next = 1'b0;
        bytes_queued++;
    endfunction

    function automatic void push_stored(input logic [7:0] v);
        if (v == sfcr_pkg::SYM_START || v == sfcr_pkg::SYM_END || v == sfcr_pkg::SYM_ESC) begin
            push_raw(sfcr_pkg::SYM_ESC);
            push_raw(~v);
        end else begin
            push_raw(v);
        end
    endfunction

    function automatic void push_vals(input int from, input int upto);
        for (int i = from; i < upto; i++) begin
            push_stored(frame_vals[i]);
        end
    endfunction

    // append the CRC, high byte first, over frame_vals from the current start value
    function automatic void seal_frame(input bit spoil);
        logic [15:0] c;
        c = cfg_crc_init;
        foreach (frame_vals[i]) begin
            c = crc16_step(c, frame_vals[i]);
        end
        if (spoil) begin
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        end
        frame_vals.push_back(c[15:8]);
        frame_vals.push_back(c[7:0]);
    endfunction

    function automatic void make_frame(input int n, input bit spoil);
        frame_vals.delete();
        repeat (n) frame_vals.push_back(pick_payload());
        seal_frame(spoil);
    endfunction

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_link_bytes.size() != 0 || (rx_ch.valid && !rx_taken) ||
               due_results.size() != 0);
    endtask

    task automatic cfg_write(input logic [sfcr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] d);
        @(negedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [12:0] len, input logic [15:0] init);
        cfg_write(sfcr_pkg::CFG_MAX_LENGTH, 16'(len));
        cfg_write(sfcr_pkg::CFG_CRC_INIT, init);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    always #2 i_clk = ~i_clk;

    // link byte source and result sink pacing
    always @(negedge i_clk) begin : link_driver
        t_link_byte nxt;
        if (rx_ch.valid && !rx_taken) begin
            // hold until the transfer happens
        end else if (rx_gap > 0) begin
            rx_ch.valid <= 1'b0;
            rx_gap--;
        end else if (pending_link_bytes.size() != 0 &&
                     !(pending_link_bytes[0].drain && due_results.size() != 0)) begin
            nxt = pending_link_bytes.pop_front();
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= nxt.value;
            rx_gap = rx_idle_on ? pick_gap() : 0;
        end else begin
            rx_ch.valid <= 1'b0;
        end

        if (res_stall > 0) begin
            res_ch.ready <= 1'b0;
            res_stall--;
        end else begin
            res_ch.ready <= 1'b1;
            if (res_idle_on && $urandom_range(0, 3) == 0) begin
                res_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_deframe_result want;
        rx_taken = 1'b0;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.reg_index == sfcr_pkg::CFG_MAX_LENGTH) begin
                    cfg_max_length = cfg_ch.wr_data[12:0];
                end else if (cfg_ch.reg_index == sfcr_pkg::CFG_CRC_INIT) begin
                    cfg_crc_init = cfg_ch.wr_data;
                end
            end
            if (rx_ch.valid && rx_ch.ready) begin
                rx_taken = 1'b1;
                due_results.push_back(deframe_byte(rx_ch.rx_byte));
            end
            if (res_ch.valid && res_ch.ready) begin
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result: ev=%0d data=%h idx=%0d len=%0d",
                                 res_ch.event_res, res_ch.data_byte, res_ch.byte_index,
                                 res_ch.payload_length);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (res_ch.event_res !== want.ev || res_ch.data_byte !== want.data ||
                        res_ch.byte_index !== want.index ||
                        res_ch.payload_length !== want.plen) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                                     want.ev, want.data, want.index, want.plen,
                                     res_ch.event_res, res_ch.data_byte, res_ch.byte_index,
                                     res_ch.payload_length);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_stuffed_frame_crc16_receiver: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int          kind;
        int          limit;
        int          room;
        int          n;
        int          phase_mark;
        logic [12:0] new_len;
        logic [15:0] new_init;

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        rx_ch.valid      = 1'b0;
        rx_ch.rx_byte    = 8'h00;
        res_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = sfcr_pkg::CFG_MAX_LENGTH;
        cfg_ch.wr_data   = 16'h0000;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bytes ahead of any start byte form a frame begun at reset
        frame_vals = '{8'h00, 8'hFF};
        seal_frame(1'b0);
        push_vals(0, frame_vals.size());
        push_raw(sfcr_pkg::SYM_END);
        push_raw(sfcr_pkg::SYM_START);
        push_raw(sfcr_pkg::SYM_END);
        push_raw(sfcr_pkg::SYM_START);
        repeat (3) push_raw(8'h41);
        push_raw(sfcr_pkg::SYM_END);
        // escaped specials inside a good frame, sent after a full drain
        drain_next = 1'b1;
        frame_vals = '{sfcr_pkg::SYM_START, sfcr_pkg::SYM_END, sfcr_pkg::SYM_ESC};
        seal_frame(1'b0);
        push_raw(sfcr_pkg::SYM_START);
        push_vals(0, frame_vals.size());
        push_raw(sfcr_pkg::SYM_END);
        push_raw(sfcr_pkg::SYM_ESC);
        push_raw(8'h00);
        push_raw(sfcr_pkg::SYM_ESC);
        push_raw(sfcr_pkg::SYM_ESC);
        push_raw(sfcr_pkg::SYM_START);
        make_frame(4, 1'b1);
        push_vals(0, frame_vals.size());
        push_raw(sfcr_pkg::SYM_END);
        // overrun the reset length limit
        push_raw(sfcr_pkg::SYM_START);
        make_frame(256, 1'b0);
        push_vals(0, frame_vals.size());
        push_raw(sfcr_pkg::SYM_END);
        wait_quiet();

        set_regs(13'd4, 16'h0000);
        push_raw(sfcr_pkg::SYM_START);
        make_frame(2, 1'b0);
        push_vals(0, frame_vals.size());
        push_raw(sfcr_pkg::SYM_END);
        // escaped byte landing in a full frame
        frame_vals = '{8'h11, 8'h22, 8'h33, 8'h44, sfcr_pkg::SYM_END};
        push_raw(sfcr_pkg::SYM_START);
        push_vals(0, frame_vals.size());
        push_raw(sfcr_pkg::SYM_END);
        wait_quiet();

        // new start value mid-frame applies only at the next restart
        set_regs(13'd4096, 16'hFFFF);
        push_raw(sfcr_pkg::SYM_START);
        make_frame(6, 1'b0);
        push_vals(0, 4);
        wait_quiet();
        set_regs(13'd4096, 16'h0000);
        push_vals(4, frame_vals.size());
        push_raw(sfcr_pkg::SYM_END);
        push_raw(sfcr_pkg::SYM_START);
        make_frame(3, 1'b0);
        push_vals(0, frame_vals.size());
        push_raw(sfcr_pkg::SYM_END);
        // lower the limit below the count of an open frame
        push_raw(sfcr_pkg::SYM_START);
        make_frame(20, 1'b0);
        push_vals(0, 10);
        wait_quiet();
        set_regs(13'd4, 16'hA5C3);
        push_raw(8'h55);
        push_raw(sfcr_pkg::SYM_START);
        make_frame(2, 1'b0);
        push_vals(0, frame_vals.size());
        push_raw(sfcr_pkg::SYM_END);
        wait_quiet();

        // long frame, run back to back
        rx_idle_on  = 1'b0;
        res_idle_on = 1'b0;
        set_regs(13'd4096, 16'($urandom_range(0, 65535)));
        push_raw(sfcr_pkg::SYM_START);
        make_frame(200, 1'b0);
        push_vals(0, frame_vals.size());
        push_raw(sfcr_pkg::SYM_END);
        wait_quiet();

        rx_idle_on  = 1'b1;
        res_idle_on = 1'b1;
        phase_mark  = bytes_queued;
        while (bytes_queued < ITEM_GOAL) begin
            if (bytes_queued - phase_mark >= 180) begin
                wait_quiet();
                rx_idle_on  = ($urandom_range(0, 3) != 0);
                res_idle_on = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 5))
                    0: new_len = 13'd4;
                    1: new_len = 13'd5;
                    2: new_len = 13'($urandom_range(6, 40));
                    3: new_len = 13'($urandom_range(4, 300));
                    4: new_len = 13'd4096;
                    default: new_len = 13'd256;
                endcase
                case ($urandom_range(0, 3))
                    0: new_init = 16'h0000;
                    1: new_init = 16'hFFFF;
                    default: new_init = 16'($urandom_range(0, 65535));
                endcase
                set_regs(new_len, new_init);
                phase_mark = bytes_queued;
            end
            kind  = $urandom_range(0, 99);
            limit = length_cap();
            room  = limit - 2;
            if (kind < 78) begin
                case ($urandom_range(0, 19))
                    0: n = $urandom_range(0, (room > 300) ? 300 : room);
                    1, 2, 3, 4: n = $urandom_range(0, (room > 60) ? 60 : room);
                    default: n = $urandom_range(0, (room > 12) ? 12 : room);
                endcase
                if (kind >= 70 && limit <= 300) begin
                    n = room + $urandom_range(1, 3);
                end
                push_raw(sfcr_pkg::SYM_START);
                make_frame(n, kind >= 60 && kind < 70);
                push_vals(0, frame_vals.size());
                push_raw(sfcr_pkg::SYM_END);
            end else if (kind < 85) begin
                push_raw(sfcr_pkg::SYM_ESC);
                push_raw(8'($urandom_range(0, 255)));
            end else if (kind < 92) begin
                repeat ($urandom_range(1, 8)) push_raw(8'($urandom_range(0, 255)));
            end else if (kind < 97) begin
                // abandon a frame by starting another
                push_raw(sfcr_pkg::SYM_START);
                repeat ($urandom_range(0, 5)) push_stored(pick_payload());
            end else begin
                drain_next = 1'b1;
            end
        end

        wait_quiet();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && due_results.size() == 0) begin
            $display("tb_stuffed_frame_crc16_receiver: clean");
        end else begin
            $display("tb_stuffed_frame_crc16_receiver: errors");
        end
        $finish;
    end

endmodule
